// File: rtl/cwt_pkg.sv
// cwt_pkg: shared types and constants for the commit watermark tracker.
// No dependencies.
`default_nettype none

package cwt_pkg;

	localparam int VER_W = 64;
	localparam int ST_W  = 2;

	// result status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_STALE = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

	// broadcast control into the row of pending cells
	typedef struct packed {
		logic shift; // every cell takes its upper neighbor's bit
		logic set;   // the addressed cell marks itself pending
	} cwt_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/commit_watermark_tracker.sv
// commit_watermark_tracker: in-order completion watermark over a row of pending cells.
// Depends on cwt_pkg and cwt_cell.
//
//  channel | handshake                   | payload
//  --------+-----------------------------+----------------------------------------
//  in      | in_valid  / in_stall (out)  | done_version[63:0]
//  out     | out_valid / out_stall (in)  | watermark[63:0], advanced, status[1:0]
//
// An item is accepted, then evaluated. An advance adds a drain that finds the end of the
// run and shifts out each pending version in turn; each version drains only once.
// The drain walks the cell row one shift per cycle.
// Reset gives watermark 1 and an empty window, with no clearing pass.
// A result waits in the output register under out_stall; the next item is taken
// meanwhile and only holds in its final cycle if the register is still full.
`default_nettype none

module commit_watermark_tracker #(
	parameter int WINDOW = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] done_version,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      watermark,
	output logic             advanced,
	output logic [1:0]       status
);
	import cwt_pkg::*;

	localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	// sequencer codes
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EVAL  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_WAIT  = 2'd3;

	logic [1:0]       state_q, state_d;
	logic [VER_W-1:0] ver_q;
	logic [VER_W-1:0] mark_q, mark_d;
	logic             res_adv_q, res_adv_d;
	logic [ST_W-1:0]  res_st_q, res_st_d;
	logic             out_valid_q;
	logic [VER_W-1:0] out_mark_q;
	logic             out_adv_q;
	logic [ST_W-1:0]  out_st_q;

	logic [VER_W-1:0]  diff;
	logic              is_stale, is_range, is_next, is_dup;
	logic [IDX_W-1:0]  sel_idx;
	logic              mark_max;
	logic              out_free;
	logic              fin;
	cwt_ctrl_t         ctrl;
	logic [WINDOW-1:0] pend_vec, hit_vec;

	// window classification, one wide subtract and compare
	assign diff     = ver_q - mark_q;
	assign is_stale = (ver_q <= mark_q);
	assign is_range = (diff > VER_W'(WINDOW));
	assign is_next  = (diff == VER_W'(1));
	assign sel_idx  = diff[IDX_W-1:0] - IDX_W'(1);  // cell of version ver_q
	assign is_dup   = |hit_vec;
	assign mark_max = &mark_q;
	assign out_free = !out_valid_q || !out_stall;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign watermark = out_mark_q;
	assign advanced  = out_adv_q;
	assign status    = out_st_q;

	// row of pending cells, cell i holds version mark + 1 + i
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		logic up;
		if (i == WINDOW - 1) begin : g_top
			assign up = 1'b0;
		end else begin : g_mid
			assign up = pend_vec[i+1];
		end
		cwt_cell #(
			.IDX_W (IDX_W),
			.IDX   (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.sel_idx (sel_idx),
			.up_pend (up),
			.pend    (pend_vec[i]),
			.hit     (hit_vec[i])
		);
	end

	always_comb begin
		state_d    = state_q;
		mark_d     = mark_q;
		res_adv_d  = res_adv_q;
		res_st_d   = res_st_q;
		ctrl.shift = 1'b0;
		ctrl.set   = 1'b0;
		fin        = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				res_adv_d = 1'b0;
				res_st_d  = ST_OK;
				if (is_stale) begin
					res_st_d = ST_STALE;
					fin      = 1'b1;
				end else if (is_range) begin
					res_st_d = ST_RANGE;
					fin      = 1'b1;
				end else if (is_next) begin
					// move onto this version, then chase the run
					mark_d     = ver_q;
					res_adv_d  = 1'b1;
					ctrl.shift = 1'b1;
					state_d    = S_DRAIN;
				end else if (is_dup) begin
					res_st_d = ST_STALE;
					fin      = 1'b1;
				end else begin
					ctrl.set = 1'b1;
					fin      = 1'b1;
				end
			end
			S_DRAIN: begin
				if (pend_vec[0] && !mark_max) begin
					mark_d     = mark_q + VER_W'(1);
					ctrl.shift = 1'b1;
				end else begin
					fin = 1'b1;
				end
			end
			S_WAIT: begin
				fin = 1'b1;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin) begin
			state_d = out_free ? S_IDLE : S_WAIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mark_q      <= VER_W'(1);
			res_adv_q   <= 1'b0;
			res_st_q    <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			mark_q    <= mark_d;
			res_adv_q <= res_adv_d;
			res_st_q  <= res_st_d;
			if (fin && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ver_q <= done_version;
		end
		if (fin && out_free) begin
			out_mark_q <= mark_d;
			out_adv_q  <= res_adv_d;
			out_st_q   <= res_st_d;
		end
	end

	// the run is fully drained whenever the block waits for a new item
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !mark_max) |-> !pend_vec[0])
		else $error("pending bit left at watermark + 1");

	a_mark_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> mark_q >= $past(mark_q))
		else $error("watermark moved backward");

	a_drain_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DRAIN |=>
			(mark_q == $past(mark_q)) || (mark_q == $past(mark_q) + VER_W'(1)))
		else $error("drain moved watermark by more than one");

	a_adv_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_adv_q) |-> out_st_q == ST_OK)
		else $error("advance reported with an ignore status");

endmodule

`default_nettype wire

// File: rtl/cwt_cell.sv
// cwt_cell: one pending flag of the window, version mark + 1 + IDX.
// Depends on cwt_pkg.
`default_nettype none

module cwt_cell #(
	parameter int IDX_W = 6,
	parameter int IDX   = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cwt_pkg::cwt_ctrl_t ctrl,
	input  wire logic [IDX_W-1:0]  sel_idx,
	input  wire logic              up_pend,
	output logic                   pend,
	output logic                   hit
);
	import cwt_pkg::*;

	logic sel;
	logic pend_q;

	assign sel  = (sel_idx == IDX_W'(IDX));
	assign pend = pend_q;
	assign hit  = pend_q & sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (ctrl.shift) begin
			pend_q <= up_pend;
		end else if (ctrl.set && sel) begin
			pend_q <= 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: tb/cwt_result_checker.sv
// cwt_result_checker: watches both channels of the commit watermark tracker,
// predicts each result and compares it. Depends on cwt_pkg.
`default_nettype none

module cwt_result_checker #(
	parameter int WINDOW = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [63:0] done_version,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [63:0] watermark,
	input  wire logic        advanced,
	input  wire logic [1:0]  status,
	output int               mismatches,
	output int               in_flight
);
	timeunit 1ns;
	timeprecision 1ps;

	import cwt_pkg::*;

	typedef struct packed {
		logic [63:0]     wmark;
		logic            adv;
		logic [ST_W-1:0] st;
	} wm_result_t;

	logic [63:0]       mark_q;
	logic [WINDOW-1:0] pend_q;
	wm_result_t        wm_expected[$];

	function automatic int unsigned slot_of(input logic [63:0] ver);
		return 32'(ver % 64'(WINDOW));
	endfunction

	// one completion against the watermark and the pending window
	task automatic track_completion(input logic [63:0] ver, output wm_result_t r);
		logic [63:0] gap;
		r.adv = 1'b0;
		r.st  = ST_OK;
		if (ver <= mark_q) begin
			r.st = ST_STALE;
		end else begin
			gap = ver - mark_q;
			if (gap > 64'(WINDOW)) begin
				r.st = ST_RANGE;
			end else if (gap == 64'd1) begin
				mark_q = ver;
				r.adv  = 1'b1;
				while (mark_q != '1 && pend_q[slot_of(mark_q + 64'd1)]) begin
					mark_q = mark_q + 64'd1;
					pend_q[slot_of(mark_q)] = 1'b0;
				end
			end else if (pend_q[slot_of(ver)]) begin
				r.st = ST_STALE;
			end else begin
				pend_q[slot_of(ver)] = 1'b1;
			end
		end
		r.wmark = mark_q;
	endtask

	initial begin
		mismatches = 0;
		in_flight  = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		wm_result_t r;
		if (!arst_n) begin
			mark_q = 64'd1;
			pend_q = '0;
			wm_expected.delete();
		end else begin
			if (in_valid && !in_stall) begin
				track_completion(done_version, r);
				wm_expected = {wm_expected, r};
			end
			if (out_valid && !out_stall) begin
				if (wm_expected.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result with nothing expected: wm %h adv %b status %0d",
							$realtime, watermark, advanced, status);
					mismatches++;
				end else begin
					r = wm_expected.pop_front();
					if (watermark !== r.wmark || advanced !== r.adv || status !== r.st) begin
						if (mismatches < 10)
							$display("%0t: mismatch: wm exp %h got %h, adv exp %b got %b,",
								$realtime, r.wmark, watermark, r.adv, advanced,
								" status exp %0d got %0d", r.st, status);
						mismatches++;
					end
				end
			end
		end
		in_flight = wm_expected.size();
	end

endmodule

`default_nettype wire

// File: tb/tb_commit_watermark_tracker.sv
// tb_commit_watermark_tracker: stimulus and verdict for the commit watermark tracker.
// Depends on commit_watermark_tracker and cwt_result_checker, which does all checking.
`default_nettype none

module tb_commit_watermark_tracker;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW      = 64;
	localparam int PHASE_ITEMS = 430;     // well-formed completions per idling phase
	localparam int CYCLE_LIMIT = 400000;  // far above the slowest correct run

	typedef enum logic [1:0] {
		NOISE_STALE,
		NOISE_DUP,
		NOISE_BEYOND
	} noise_kind_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic [63:0] done_version = '0;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic [63:0] watermark;
	logic        advanced;
	logic [1:0]  status;

	int          mismatches;
	int          in_flight;
	int unsigned idle_pct  = 0;   // sender gap odds, percent per cycle
	int unsigned stall_pct = 0;   // receiver stall odds, percent per cycle
	int unsigned cycles    = 0;

	// highest watermark the stimulus has completed up to; every version at or
	// below it has been sent, so anything at or below it is stale for sure
	logic [63:0] done_top = 64'd1;

	always #5 clk = ~clk;

	commit_watermark_tracker #(
		.WINDOW(WINDOW)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.done_version(done_version),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.watermark   (watermark),
		.advanced    (advanced),
		.status      (status)
	);

	cwt_result_checker #(
		.WINDOW(WINDOW)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.done_version(done_version),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.watermark   (watermark),
		.advanced    (advanced),
		.status      (status),
		.mismatches  (mismatches),
		.in_flight   (in_flight)
	);

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_commit_watermark_tracker: done, errors");
			$finish;
		end
	end

	// present one version, with random gaps first; returns at the accepting edge
	task automatic offer_version(input logic [63:0] ver);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		done_version <= ver;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// one version that must be ignored: stale, a repeat from the running batch,
	// or past the window even if the whole batch has drained
	task automatic offer_noise(input logic [63:0] batch[$], input int sent,
			input logic [63:0] batch_top);
		noise_kind_t kind;
		logic [63:0] ver;
		kind = noise_kind_t'($urandom_range(2));
		if (kind == NOISE_DUP && sent == 0)
			kind = NOISE_STALE;
		case (kind)
			NOISE_STALE: begin
				if ($urandom_range(1))
					ver = done_top - 64'($urandom_range(1));
				else
					ver = {$urandom, $urandom} % (done_top + 64'd1);
			end
			NOISE_DUP: begin
				ver = batch[$urandom_range(sent - 1)];
			end
			default: begin
				// just past the far edge, a bit further past it, or anywhere up high
				case ($urandom_range(2))
					0:       ver = batch_top + 64'(WINDOW) + 64'd1;
					1:       ver = batch_top + 64'(WINDOW) + 64'd1 + 64'($urandom_range(1000));
					default: ver = {1'b1, 31'($urandom), $urandom};
				endcase
			end
		endcase
		offer_version(ver);
	endtask

	// Batches of consecutive versions above done_top, sent in shuffled order.
	// Sometimes the lowest one goes last so the whole batch drains in one step;
	// full-window batches give the longest drain the block allows.
	task automatic feed_batches(input int n_items);
		logic [63:0] batch[$];
		logic [63:0] tmp;
		int          count;
		int          len;
		int          j;
		count = 0;
		while (count < n_items) begin
			case ($urandom_range(9))
				0:       len = WINDOW;
				1, 2:    len = $urandom_range(WINDOW, 9);
				default: len = $urandom_range(8, 1);
			endcase
			batch.delete();
			for (int i = 1; i <= len; i++)
				batch = {batch, done_top + 64'(i)};
			for (int i = len - 1; i > 0; i--) begin
				j        = $urandom_range(i);
				tmp      = batch[i];
				batch[i] = batch[j];
				batch[j] = tmp;
			end
			if ($urandom_range(2) == 0) begin
				for (int i = 0; i < len; i++) begin
					if (batch[i] == done_top + 64'd1) begin
						batch[i]       = batch[len - 1];
						batch[len - 1] = done_top + 64'd1;
					end
				end
			end
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(99) < 12)
					offer_noise(batch, i, done_top + 64'(len));
				offer_version(batch[i]);
				count++;
			end
			done_top = done_top + 64'(len);
		end
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// directed: watermark starts at 1 with an empty window
		offer_version(64'd1);                    // equal to the watermark: stale
		offer_version(64'd0);                    // below it: stale
		offer_version('1);                       // all ones: beyond the window
		offer_version(64'd2 + 64'(WINDOW));      // one past the window
		offer_version(64'h8000_0000_0000_0000);  // beyond
		offer_version(64'h5555_5555_5555_5555);  // beyond
		offer_version(64'hAAAA_AAAA_AAAA_AAAA);  // beyond
		offer_version(64'd3);                    // held out of order
		offer_version(64'd3);                    // already pending: duplicate
		offer_version(64'd1 + 64'(WINDOW));      // held at the far edge of the window
		offer_version(64'd2);                    // advance, drains 3
		offer_version(64'd2);                    // now stale
		offer_version(64'd3);                    // drained, so stale
		offer_version(64'd6);                    // held
		offer_version(64'd5);                    // held
		offer_version(64'd4);                    // advance, drains 5 and 6
		offer_version(64'd8);                    // held
		offer_version(64'd7);                    // advance, drains 8
		done_top = 64'd8;
		// the far-edge version stays pending and is later sent again, as a duplicate or,
		// once drained, as stale; the top of the 64-bit range cannot be reached from reset in any run

		// random part, one phase per idling mix; knobs change at an accepting
		// edge so the stall driver only sees them at the following falling edge
		feed_batches(PHASE_ITEMS);
		idle_pct = 75;
		feed_batches(PHASE_ITEMS);
		idle_pct  = 0;
		stall_pct = 75;
		feed_batches(PHASE_ITEMS);
		idle_pct  = 37;
		stall_pct = 37;
		feed_batches(PHASE_ITEMS);

		@(negedge clk);
		in_valid <= 1'b0;
		while (in_flight != 0) @(negedge clk);
		// one result per item, so only a stray extra result could still show up
		repeat (2 * WINDOW) @(negedge clk);

		if (mismatches == 0)
			$display("tb_commit_watermark_tracker: done, clean");
		else
			$display("tb_commit_watermark_tracker: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
